// ===== sv/tccw_pkg.sv =====
package tccw_pkg;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_COPY,
		ST_FILL,
		ST_RESP
	} state_t;

	localparam logic REG_BACK = 1'b0;
	localparam logic REG_FORE = 1'b1;

	localparam logic [3:0] BACK_RESET = 4'h0;
	localparam logic [3:0] FORE_RESET = 4'hF;

	localparam logic [7:0] CH_BS         = 8'h08;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_LAST_PRINT = 8'h7F;

	localparam int TAB_STOP = 8;

endpackage

// ===== sv/tccw_ram.sv =====
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/text_console_char_writer.sv =====
// Text console writer: a cursor plus a COLUMNS x ROWS screen of 16-bit cells
// (attribute in the high byte, character in the low byte).
// Command channel: an item (operation, char_code, cell_address) is taken at a
// clock edge where start is high and busy is low. Operations are put
// character, clear screen and read cell; code 3 does nothing.
// Every item gives exactly one result: done is high for one cycle with
// cursor_location (row*COLUMNS+column after the item) and cell_data (the cell
// for a read, zero otherwise). The receiver cannot stall; results are never
// held back.
// A put without scroll, a read and a no-op go through ST_RESP, from which done
// is registered. A put that scrolls copies (ROWS-1)*COLUMNS cells and blanks
// COLUMNS cells, one cell per cycle through the single write port of the screen
// RAM (blanking waits for a pending copy write). A clear blanks all cells.
// One item at a time; busy is high for the whole item.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 = background colour,
// 1 = foreground colour; always ready, write only while idle.
// Reset: cursor homes, colours go to 0/15, and a clearing pass zeroes the
// screen with busy high; configuration is taken then.
module text_console_char_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  char_code,
	input  logic [10:0] cell_address,
	output logic        done,
	output logic [10:0] cursor_location,
	output logic [15:0] cell_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	import tccw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CLW   = $clog2(COLUMNS + TAB_STOP);
	localparam int RW    = $clog2(ROWS + 1);

	localparam logic [AW-1:0]  COLS_A     = AW'(COLUMNS);
	localparam logic [AW-1:0]  LAST_CELL  = AW'(CELLS - 1);
	localparam logic [AW-1:0]  FILL_BASE  = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0]  LAST_COPY  = AW'((ROWS - 1) * COLUMNS - 1);
	localparam logic [CLW-1:0] COLS_C     = CLW'(COLUMNS);
	localparam logic [CLW-1:0] TAB_C      = CLW'(TAB_STOP);
	localparam logic [CLW-1:0] TAB_MASK   = ~CLW'(TAB_STOP - 1);
	localparam logic [RW-1:0]  ROWS_R     = RW'(ROWS);
	localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);

	state_t state_q, state_d;

	logic [3:0]     back_q, fore_q;
	logic [CLW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic [AW-1:0]  ptr_q;
	logic [1:0]     op_q;
	logic           rd_ok_q;
	logic           done_q;
	logic [10:0]    loc_q;
	logic [15:0]    data_q;

	logic           cp_valid_s1;
	logic [AW-1:0]  cp_addr_s1;

	logic           accept;
	logic           printable;
	logic [CLW-1:0] col_n, col_w;
	logic [RW-1:0]  row_n, row_w;
	logic           scroll;
	logic [AW-1:0]  cur_idx;
	logic [31:0]    cur_ext, addr_ext;
	logic [7:0]     attr;
	logic           fill_we;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [15:0]    ram_wdata, ram_rdata;

	assign accept    = start && (state_q == ST_IDLE);
	assign attr      = {back_q, fore_q};
	assign printable = (char_code inside {[CH_SPACE:CH_LAST_PRINT]});
	assign cur_idx   = AW'(row_q) * COLS_A + AW'(col_q);
	assign cur_ext   = 32'(cur_idx);
	assign addr_ext  = 32'(cell_address);
	assign fill_we   = (state_q == ST_INIT || state_q == ST_FILL) && !cp_valid_s1;

	// cursor motion for a put
	always_comb begin
		col_w = col_q;
		row_w = row_q;
		case (char_code)
			CH_BS: begin
				if (col_q != '0) begin
					col_w = col_q - CLW'(1);
				end
			end
			CH_TAB: col_w = (col_q + TAB_C) & TAB_MASK;
			CH_CR:  col_w = '0;
			CH_LF: begin
				col_w = '0;
				row_w = row_q + RW'(1);
			end
			default: begin
				if (printable) begin
					col_w = col_q + CLW'(1);
				end
			end
		endcase
		col_n = col_w;
		row_n = row_w;
		if (col_w >= COLS_C) begin
			col_n = '0;
			row_n = row_w + RW'(1);
		end
		scroll = (row_n >= ROWS_R);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (ptr_q == LAST_CELL) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (operation == OP_PUT && scroll) begin
						state_d = ST_COPY;
					end else if (operation == OP_CLEAR) begin
						state_d = ST_FILL;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_COPY: begin
				if (ptr_q == LAST_COPY) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (fill_we && ptr_q == LAST_CELL) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM ports and handshake outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		ram_raddr = addr_ext[AW-1:0];
		if (state_q == ST_COPY) begin
			ram_raddr = ptr_q + COLS_A;
		end
		if (cp_valid_s1) begin
			ram_we    = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = ram_rdata;
		end else if (fill_we) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q;
			ram_wdata = (state_q == ST_INIT) ? 16'h0000 : {attr, CH_SPACE};
		end else if (accept && operation == OP_PUT && printable) begin
			ram_we    = 1'b1;
			ram_waddr = cur_idx;
			ram_wdata = {attr, char_code};
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign done            = done_q;
	assign cursor_location = loc_q;
	assign cell_data       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			back_q      <= BACK_RESET;
			fore_q      <= FORE_RESET;
			col_q       <= '0;
			row_q       <= '0;
			ptr_q       <= '0;
			cp_valid_s1 <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			cp_valid_s1 <= (state_q == ST_COPY);
			done_q      <= (state_q == ST_RESP);

			if (cfg_valid) begin
				if (cfg_index == REG_BACK) begin
					back_q <= cfg_data;
				end else begin
					fore_q <= cfg_data;
				end
			end

			case (state_q)
				ST_INIT: ptr_q <= ptr_q + AW'(1);
				ST_IDLE: begin
					if (start) begin
						if (operation == OP_PUT) begin
							col_q <= col_n;
							row_q <= scroll ? LAST_ROW : row_n;
						end else if (operation == OP_CLEAR) begin
							col_q <= '0;
							row_q <= '0;
						end
						ptr_q <= '0;
					end
				end
				ST_COPY: ptr_q <= (ptr_q == LAST_COPY) ? FILL_BASE : ptr_q + AW'(1);
				ST_FILL: begin
					if (fill_we) begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= ptr_q;
		if (accept) begin
			op_q    <= operation;
			rd_ok_q <= (addr_ext < 32'(CELLS));
		end
		if (state_q == ST_RESP) begin
			loc_q  <= cur_ext[10:0];
			data_q <= (op_q == OP_READ && rd_ok_q) ? ram_rdata : 16'h0000;
		end
	end

	tccw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule
